/* rtl/core/biquad_highpass_filter_unit_assert.svh */
// Assertion macros for the biquad high-pass filter unit.
// Each macro expects clk and rst to be in scope at the point of use.
`ifndef BIQUAD_HIGHPASS_FILTER_UNIT_ASSERT_SVH
`define BIQUAD_HIGHPASS_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define BHF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BHF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BHF_ASSERT_IMP(lbl, ante, cons, msg)
`define BHF_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/bhf_pkg.sv */
package bhf_pkg;

  localparam int COEF_BITS    = 32;
  localparam int COEF_FRAC    = 29;
  localparam int NUM_COEFS    = 5;
  localparam int CFG_IDX_BITS = 3;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic signed [COEF_BITS-1:0] COEF_B0_RESET = 32'sh2000_0000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_set_t;

  typedef struct packed {
    logic chan;
    logic clear;
  } item_tag_t;

  typedef struct packed {
    logic pop;
    logic s1_valid;
    logic s1_adv;
  } back_status_t;

endpackage

/* rtl/core/bhf_front.sv */
module bhf_front import bhf_pkg::*; #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24,
  parameter int CIDX_W      = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          channel,
  input  logic                          first_of_buffer,
  output logic                          q_valid,
  input  logic                          q_pop,
  output logic signed [SAMPLE_BITS-1:0] q_sample,
  output item_tag_t                     q_tag,
  output logic        [CIDX_W-1:0]      q_cidx
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [SAMPLE_BITS-1:0] samples [QUEUE_DEPTH];
  item_tag_t                     tags    [QUEUE_DEPTH];
  logic        [CIDX_W-1:0]      cidxs   [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  logic [CIDX_W-1:0] cidx_in;
  item_tag_t         tag_in;

  // Fold the channel onto the available history sets.
  assign cidx_in      = (CHANNELS == 1) ? '0 : CIDX_W'(channel);
  assign tag_in.chan  = channel;
  assign tag_in.clear = first_of_buffer;

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  assign q_sample = samples[rd_ptr];
  assign q_tag    = tags[rd_ptr];
  assign q_cidx   = cidxs[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      samples[wr_ptr] <= sample_in;
      tags[wr_ptr]    <= tag_in;
      cidxs[wr_ptr]   <= cidx_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

/* rtl/core/bhf_back.sv */
module bhf_back import bhf_pkg::*; #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24,
  parameter int CIDX_W      = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  coef_set_t                     coefs,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic signed [SAMPLE_BITS-1:0] q_sample,
  input  item_tag_t                     q_tag,
  input  logic        [CIDX_W-1:0]      q_cidx,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          channel_out,
  output back_status_t                  status
);

  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + 3;
  localparam int WIDE_W = SUM_W - COEF_FRAC;

  localparam logic signed [SUM_W-1:0]  RND  = SUM_W'(2 ** (COEF_FRAC - 1));
  localparam logic signed [WIDE_W-1:0] MAXV =
    {{(WIDE_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] MINV = ~MAXV;

  logic signed [SAMPLE_BITS-1:0] x1 [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] x2 [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y1 [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y2 [CHANNELS];

  logic signed [SAMPLE_BITS-1:0] x1_rd, x2_rd, y1_rd, y2_rd;
  logic signed [PROD_W-1:0] coef_ext [NUM_COEFS];
  logic signed [PROD_W-1:0] opnd_ext [NUM_COEFS];
  logic signed [PROD_W-1:0] prod_next [NUM_COEFS];
  logic signed [PROD_W-1:0] prod [NUM_COEFS];

  logic              s1_valid;
  logic [CIDX_W-1:0] s1_cidx;
  logic              s1_chan;
  logic              s1_clear;

  logic out_load, s1_adv, s1_free, hazard, pop;
  logic signed [SUM_W-1:0]       acc;
  logic signed [WIDE_W-1:0]      y_wide;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  // History as seen by the head item; a buffer start sees all zeros.
  assign x1_rd = q_tag.clear ? '0 : x1[q_cidx];
  assign x2_rd = q_tag.clear ? '0 : x2[q_cidx];
  assign y1_rd = q_tag.clear ? '0 : y1[q_cidx];
  assign y2_rd = q_tag.clear ? '0 : y2[q_cidx];

  assign coef_ext[0] = PROD_W'(coefs.b0);
  assign coef_ext[1] = PROD_W'(coefs.b1);
  assign coef_ext[2] = PROD_W'(coefs.b2);
  assign coef_ext[3] = PROD_W'(coefs.a1);
  assign coef_ext[4] = PROD_W'(coefs.a2);
  assign opnd_ext[0] = PROD_W'(q_sample);
  assign opnd_ext[1] = PROD_W'(x1_rd);
  assign opnd_ext[2] = PROD_W'(x2_rd);
  assign opnd_ext[3] = PROD_W'(y1_rd);
  assign opnd_ext[4] = PROD_W'(y2_rd);

  always_comb begin
    for (int i = 0; i < NUM_COEFS; i++) begin
      prod_next[i] = coef_ext[i] * opnd_ext[i];
    end
  end

  // Hold the head if the multiply stage has its channel or cannot advance.
  assign out_load = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_load;
  assign s1_free  = !s1_valid || out_load;
  assign hazard   = s1_valid && (s1_cidx == q_cidx);
  assign pop      = q_valid && s1_free && !hazard;
  assign q_pop    = pop;

  assign status.pop      = pop;
  assign status.s1_valid = s1_valid;
  assign status.s1_adv   = s1_adv;

  assign acc = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2])
             - SUM_W'(prod[3]) - SUM_W'(prod[4]) + RND;
  assign y_wide = WIDE_W'(acc >>> COEF_FRAC);

  always_comb begin
    if (y_wide > MAXV) begin
      y_sat = MAXV[SAMPLE_BITS-1:0];
    end else if (y_wide < MINV) begin
      y_sat = MINV[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_wide[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        prod[i] <= prod_next[i];
      end
      s1_cidx  <= q_cidx;
      s1_chan  <= q_tag.chan;
      s1_clear <= q_tag.clear;
    end
    if (s1_adv) begin
      sample_out  <= y_sat;
      channel_out <= s1_chan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        x1[c] <= '0;
        x2[c] <= '0;
        y1[c] <= '0;
        y2[c] <= '0;
      end
    end else begin
      if (pop) begin
        x1[q_cidx] <= q_sample;
        x2[q_cidx] <= x1_rd;
      end
      if (s1_adv) begin
        y1[s1_cidx] <= y_sat;
        y2[s1_cidx] <= s1_clear ? '0 : y1[s1_cidx];
      end
    end
  end

endmodule

/* rtl/core/biquad_highpass_filter_unit.sv */
// Biquad (direct form I) filter with a separate two-sample input and output
// history per channel. Each input beat carries one signed sample, its channel
// and a first-of-buffer flag that zeroes that channel's history before the
// sample is filtered; each beat yields one result beat, rounded half up and
// saturated, tagged with the input channel. Coefficients b0, b1, b2, a1, a2
// are signed Q3.29 at write indexes 0 to 4 and may be written only while the
// block is idle. After the edge that takes a beat, it moves from the input queue
// into the multiply stage and then into the output register. Beats on
// alternating channels stream at one per cycle while out_ready is held high;
// consecutive beats on the same channel cannot overlap, held back by the output
// history that must come back from the sum stage before the next multiply of
// that channel.
`include "biquad_highpass_filter_unit_assert.svh"

module biquad_highpass_filter_unit import bhf_pkg::*; #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic        [CFG_IDX_BITS-1:0] cfg_index,
  input  logic        [COEF_BITS-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          channel,
  input  logic                          first_of_buffer,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          channel_out
);

  localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  coef_set_t    coefs;
  back_status_t st;

  logic                          q_valid;
  logic                          q_pop;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  item_tag_t                     q_tag;
  logic        [CIDX_W-1:0]      q_cidx;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= COEF_B0_RESET;
      coefs.b1 <= '0;
      coefs.b2 <= '0;
      coefs.a1 <= '0;
      coefs.a2 <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_B0:  coefs.b0 <= cfg_data;
        REG_B1:  coefs.b1 <= cfg_data;
        REG_B2:  coefs.b2 <= cfg_data;
        REG_A1:  coefs.a1 <= cfg_data;
        REG_A2:  coefs.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  bhf_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CIDX_W      (CIDX_W)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample_in       (sample_in),
    .channel         (channel),
    .first_of_buffer (first_of_buffer),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_sample        (q_sample),
    .q_tag           (q_tag),
    .q_cidx          (q_cidx)
  );

  bhf_back #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CIDX_W      (CIDX_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .coefs       (coefs),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_sample    (q_sample),
    .q_tag       (q_tag),
    .q_cidx      (q_cidx),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .channel_out (channel_out),
    .status      (st)
  );

  `BHF_ASSERT_NXT(a_s1_hold, st.s1_valid && !st.s1_adv, st.s1_valid, "multiply stage lost a beat")
  `BHF_ASSERT_IMP(a_out_rise, $rose(out_valid), $past(st.s1_adv), "result without stage advance")
  `BHF_ASSERT_IMP(a_pop_slot, st.pop && st.s1_valid, st.s1_adv, "pop into occupied stage")

endmodule

/* tb/sv/tb_biquad_highpass_filter_unit.sv */
`timescale 1ns / 100ps

module tb_biquad_highpass_filter_unit;
  import bhf_pkg::*;

  localparam int CHANNELS     = 2;
  localparam int SAMPLE_BITS  = 24;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_PRINTS   = 30;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0]   C_MAX   = 32'sh7fff_ffff;
  localparam logic signed [COEF_BITS-1:0]   C_MIN   = 32'sh8000_0000;
  localparam logic signed [COEF_BITS-1:0]   C_ONE   = 32'sh2000_0000;
  localparam logic signed [COEF_BITS-1:0]   C_HALF  = 32'sh1000_0000;

  // 1 kHz Butterworth high-pass at 44.1 kHz, Q3.29
  localparam logic signed [COEF_BITS-1:0] HP_B0 = 32'sd485411835;
  localparam logic signed [COEF_BITS-1:0] HP_B1 = -32'sd970823670;
  localparam logic signed [COEF_BITS-1:0] HP_B2 = 32'sd485411835;
  localparam logic signed [COEF_BITS-1:0] HP_A1 = -32'sd965881773;
  localparam logic signed [COEF_BITS-1:0] HP_A2 = 32'sd438894656;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          ch;
  } filtered_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
  logic [COEF_BITS-1:0]          cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_in = '0;
  logic                          channel = 1'b0;
  logic                          first_of_buffer = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          channel_out;

  // filter model state
  logic signed [COEF_BITS-1:0]   coef_q [NUM_COEFS];
  logic signed [SAMPLE_BITS-1:0] x_hist1 [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] x_hist2 [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y_hist1 [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y_hist2 [CHANNELS];

  filtered_beat_t expected_beats[$];

  bit          src_random = 1'b0;
  logic        sink_random = 1'b0;
  logic        sink_hold = 1'b0;
  int unsigned sink_stall = 0;
  int          mismatch_count = 0;
  int          beats_sent = 0;
  int          results_seen = 0;
  int          settings_loaded = 0;
  int          cycle_count = 0;

  biquad_highpass_filter_unit #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample_in       (sample_in),
    .channel         (channel),
    .first_of_buffer (first_of_buffer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sample_out      (sample_out),
    .channel_out     (channel_out)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_beats.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] filter_predict(
    input logic signed [SAMPLE_BITS-1:0] x,
    input logic                          ch,
    input logic                          clr
  );
    longint acc;
    longint lim_hi;
    longint lim_lo;
    lim_hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    lim_lo = -lim_hi - 1;
    if (clr) begin
      x_hist1[ch] = '0;
      x_hist2[ch] = '0;
      y_hist1[ch] = '0;
      y_hist2[ch] = '0;
    end
    acc = longint'(coef_q[REG_B0]) * longint'(x)
        + longint'(coef_q[REG_B1]) * longint'(x_hist1[ch])
        + longint'(coef_q[REG_B2]) * longint'(x_hist2[ch])
        - longint'(coef_q[REG_A1]) * longint'(y_hist1[ch])
        - longint'(coef_q[REG_A2]) * longint'(y_hist2[ch]);
    // round half up onto the sample grid, then clamp
    acc = (acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    if (acc > lim_hi) acc = lim_hi;
    if (acc < lim_lo) acc = lim_lo;
    x_hist2[ch] = x_hist1[ch];
    x_hist1[ch] = x;
    y_hist2[ch] = y_hist1[ch];
    y_hist1[ch] = acc[SAMPLE_BITS-1:0];
    return acc[SAMPLE_BITS-1:0];
  endfunction

  // Receiver: optional random stall before each beat, plus an optional long hold-off.
  always @(posedge clk) begin : result_sink
    int unsigned stall;
    if (rst) begin
      out_ready  <= 1'b0;
      sink_stall <= 0;
    end else if (sink_hold) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      stall = sink_random ? $urandom_range(0, 13) : 0;
      sink_stall <= stall;
      out_ready  <= (stall == 0);
    end else if (sink_stall != 0) begin
      sink_stall <= sink_stall - 1;
      out_ready  <= (sink_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    filtered_beat_t exp_beat;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_beats.size() == 0) begin
        note_mismatch($sformatf("unexpected beat sample=%0d channel=%0d",
                                sample_out, channel_out));
      end else begin
        exp_beat = expected_beats.pop_front();
        if (sample_out !== exp_beat.smp)
          note_mismatch($sformatf("result %0d sample_out=%0d, want %0d",
                                  results_seen, sample_out, exp_beat.smp));
        if (channel_out !== exp_beat.ch)
          note_mismatch($sformatf("result %0d channel_out=%0d, want %0d",
                                  results_seen, channel_out, exp_beat.ch));
      end
    end
  end

  // Call at a rising-edge step; returns at the edge that takes the beat.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x, input logic ch,
                             input logic clr);
    int unsigned gap;
    filtered_beat_t beat;
    gap = src_random ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    sample_in       <= x;
    channel         <= ch;
    first_of_buffer <= clr;
    do @(posedge clk); while (!in_ready);
    beat.smp = filter_predict(x, ch, clr);
    beat.ch  = ch;
    expected_beats.push_back(beat);
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_coef(input reg_index_t idx, input logic signed [COEF_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    coef_q[idx] = val;
  endtask

  task automatic load_coefs(input logic signed [COEF_BITS-1:0] b0, b1, b2, a1, a2);
    write_coef(REG_B0, b0);
    write_coef(REG_B1, b1);
    write_coef(REG_B2, b2);
    write_coef(REG_A1, a1);
    write_coef(REG_A2, a2);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Reset coefficients give unity gain: output equals input.
  task automatic test_passthrough();
    send_sample(SMP_MAX, 1'b0, 1'b0);
    send_sample(SMP_MIN, 1'b1, 1'b0);
    send_sample('0, 1'b0, 1'b0);
    send_sample(24'sd1, 1'b1, 1'b1);
    send_sample(-24'sd1, 1'b0, 1'b1);
    send_sample(24'sh5a5a5a, 1'b1, 1'b0);
    wait_idle();
  endtask

  task automatic test_saturation();
    load_coefs(C_MAX, 0, 0, 0, 0);
    send_sample(SMP_MAX, 1'b0, 1'b0);
    send_sample(SMP_MIN, 1'b1, 1'b0);
    wait_idle();
    load_coefs(C_MIN, 0, 0, 0, 0);
    send_sample(SMP_MIN, 1'b0, 1'b1);
    send_sample(SMP_MAX, 1'b1, 1'b1);
    wait_idle();
    // strong feedback from clamped output history
    load_coefs(C_ONE, C_MAX, C_MIN, C_MIN, C_MAX);
    send_sample(24'sd1000, 1'b0, 1'b1);
    send_sample(SMP_MAX, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Half-step results round toward plus infinity.
  task automatic test_rounding();
    load_coefs(C_HALF, 0, 0, 0, 0);
    send_sample(24'sd1, 1'b0, 1'b1);
    send_sample(-24'sd1, 1'b1, 1'b1);
    send_sample(24'sd3, 1'b0, 1'b0);
    send_sample(-24'sd3, 1'b1, 1'b0);
    send_sample(-24'sd5, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_history_clear();
    load_coefs(HP_B0, HP_B1, HP_B2, HP_A1, HP_A2);
    send_sample(24'sd400000, 1'b0, 1'b1);
    send_sample(-24'sd300000, 1'b1, 1'b1);
    send_sample(24'sd250000, 1'b0, 1'b0);
    send_sample(24'sd250000, 1'b0, 1'b0);
    send_sample(-24'sd700000, 1'b1, 1'b0);
    // clear channel 0 mid-stream; channel 1 keeps its history
    send_sample(24'sd123456, 1'b0, 1'b1);
    send_sample(24'sd99999, 1'b1, 1'b0);
    send_sample(SMP_MIN, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Hold the output off long enough for the block to fill and stall its input.
  task automatic test_input_stall();
    int k;
    src_random = 1'b0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (160) @(posedge clk);
        sink_hold <= 1'b0;
      end
      for (k = 0; k < 48; k++)
        send_sample($signed(24'($urandom)), (k < 24) ? k[0] : 1'b1, (k == 0) || (k == 24));
    join
    wait_idle();
  endtask

  task automatic test_random_buffers(input int phases, input int per_phase);
    int p;
    int n;
    int unsigned shift;
    int buf_left [CHANNELS];
    logic signed [COEF_BITS-1:0] c [NUM_COEFS];
    logic signed [SAMPLE_BITS-1:0] x;
    logic ch;
    logic clr;
    for (p = 0; p < phases; p++) begin
      for (n = 0; n < NUM_COEFS; n++) begin
        case (p % 4)
          0: c[n] = $signed($urandom) >>> 4;
          1: c[n] = $signed($urandom);
          2: begin
            case ($urandom_range(0, 3))
              0: c[n] = C_MIN;
              1: c[n] = C_MAX;
              2: c[n] = '0;
              default: c[n] = $signed($urandom);
            endcase
          end
          default: c[n] = $signed($urandom) >>> 2;
        endcase
      end
      if (p % 4 == 3) begin
        c[0] = HP_B0; c[1] = HP_B1; c[2] = HP_B2; c[3] = HP_A1; c[4] = HP_A2;
      end
      load_coefs(c[0], c[1], c[2], c[3], c[4]);
      src_random = (p % 2 == 0);
      sink_random <= (p % 4 < 2);
      buf_left = '{default: 0};
      for (n = 0; n < per_phase; n++) begin
        ch  = 1'($urandom_range(0, 1));
        clr = 1'b0;
        if (buf_left[ch] == 0) begin
          buf_left[ch] = $urandom_range(1, 32);
          clr = 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
          clr = 1'b1;  // stray clear in the middle of a buffer
        end
        buf_left[ch]--;
        shift = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
        x = $signed(SAMPLE_BITS'($urandom)) >>> shift;
        send_sample(x, ch, clr);
      end
      wait_idle();
    end
  endtask

  initial begin
    coef_q[REG_B0] = COEF_B0_RESET;
    coef_q[REG_B1] = '0;
    coef_q[REG_B2] = '0;
    coef_q[REG_A1] = '0;
    coef_q[REG_A2] = '0;
    x_hist1 = '{default: '0};
    x_hist2 = '{default: '0};
    y_hist1 = '{default: '0};
    y_hist2 = '{default: '0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_passthrough();
    test_saturation();
    test_rounding();
    test_history_clear();
    test_input_stall();
    test_random_buffers(4, 150);

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d samples on both channels under %0d coefficient sets, %0d results seen",
             beats_sent, settings_loaded, results_seen);
    $display("run included rounding ties, clamping, history clears and a long output stall");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
